// File: design/i2c_target_register_file_unit_macros.svh
// Assertion macros for the I2C target register file.
`ifndef I2C_TARGET_REGISTER_FILE_UNIT_MACROS_SVH
`define I2C_TARGET_REGISTER_FILE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define I2CTRF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2ctrf assertion failed");
`define I2CTRF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2ctrf assertion failed");
`else
`define I2CTRF_ASSERT_NOW(label, ante, cons)
`define I2CTRF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/i2ctrf_pkg.sv
// Types, codes and constants shared by the I2C target register file.
package i2ctrf_pkg;

	localparam int MAP_SIZE = 32;
	localparam int IDX_W    = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
	localparam int MASK_W   = 32;
	localparam int MASK_IDX_W = $clog2(MASK_W);

	typedef enum logic [3:0] {
		KIND_RD_ADDR_ACK  = 4'd0,
		KIND_RD_DATA_ACK  = 4'd1,
		KIND_RD_DATA_NACK = 4'd2,
		KIND_WR_ADDR_ACK  = 4'd3,
		KIND_WR_DATA_ACK  = 4'd4,
		KIND_STOP         = 4'd5,
		KIND_WR_DATA_NACK = 4'd6,
		KIND_LAST_ACK     = 4'd7,
		KIND_BUS_ERR      = 4'd8,
		KIND_OTHER        = 4'd9,
		KIND_LOCAL_WR     = 4'd10,
		KIND_LOCAL_RD     = 4'd11
	} kind_t;

	typedef enum logic [2:0] {
		ST_NONE       = 3'd0,
		ST_WDATA_NACK = 3'd1,
		ST_LAST_ACK   = 3'd2,
		ST_BUS_ERR    = 3'd3,
		ST_UNKNOWN    = 3'd4
	} status_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] data;
		logic [4:0] local_index;
	} item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic [7:0] local_data;
		logic       busy_res;
		logic [2:0] last_status;
		logic       release_bus;
	} result_t;

	typedef struct packed {
		logic [7:0] reg_ptr;
		logic [7:0] rx_count;
		logic [7:0] rd_ptr;
		logic       busy;
		status_t    status;
	} state_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [7:0]       data;
	} map_wr_t;

endpackage

// File: design/i2c_target_register_file_unit.sv
// Top level of the I2C target register file: request register, map, state and result register.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes one decoded bus event or local
//   map access per request; result channel (result_valid/result_ready/result) returns
//   exactly one result per request, in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes readonly_mask; cfg_ready is
//   always high. Write it only while no request is in flight.
// Path: an accepted request waits in the request register; its result is registered in the result register.
// Throughput: one request per cycle when not stalled; the request register feeds the
//   event decode, which reads one map entry and updates the pointers before the result register.
// Reset: arst_n clears the map to zero, all pointers, counters, busy, status and
//   readonly_mask, and empties both registers.
// Stall: while result_ready is low the result holds; one more request may wait in
//   the request register, then item_ready drops until the result is taken.
//
`include "i2c_target_register_file_unit_macros.svh"
module i2c_target_register_file_unit
	import i2ctrf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MASK_W-1:0] cfg_data
);

	logic              s1_valid_s1;
	item_t             item_s1;
	logic              adv;
	logic [MASK_W-1:0] ro_mask_q;
	state_t            state_q;
	state_t            st_nxt;
	map_wr_t           wr;
	result_t           res;
	logic [IDX_W-1:0]  rd_idx;
	logic [7:0]        map_q [MAP_SIZE];

	assign adv        = s1_valid_s1 && (!result_valid || result_ready);
	assign item_ready = !s1_valid_s1 || adv;
	assign cfg_ready  = 1'b1;

	i2ctrf_step u_step (
		.item    (item_s1),
		.st      (state_q),
		.ro_mask (ro_mask_q),
		.rd_data (map_q[rd_idx]),
		.rd_idx  (rd_idx),
		.st_nxt  (st_nxt),
		.wr      (wr),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			s1_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_mask_q <= '0;
		end else if (cfg_valid) begin
			ro_mask_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{reg_ptr: 8'd0, rx_count: 8'd0, rd_ptr: 8'd0, busy: 1'b0,
				status: ST_NONE};
		end else if (adv) begin
			state_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAP_SIZE; k++) begin
				map_q[k] <= 8'h00;
			end
		end else if (adv && wr.en) begin
			map_q[wr.idx] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= res;
		end
	end

	`I2CTRF_ASSERT_NOW(a_release_has_status, result_valid && result.release_bus, result.last_status == ST_WDATA_NACK || result.last_status == ST_LAST_ACK || result.last_status == ST_BUS_ERR)
	`I2CTRF_ASSERT_NOW(a_result_matches_state, result_valid, result.busy_res == state_q.busy && result.last_status == state_q.status)
	`I2CTRF_ASSERT_NOW(a_full_blocks_input, s1_valid_s1 && result_valid && !result_ready, !item_ready)
	`I2CTRF_ASSERT_NEXT(a_adv_gives_result, adv, result_valid)

endmodule

// File: design/i2ctrf_step.sv
// Event decode and next-state logic for one I2C target request.
module i2ctrf_step
	import i2ctrf_pkg::*;
(
	input  item_t              item,
	input  state_t             st,
	input  logic [MASK_W-1:0]  ro_mask,
	input  logic [7:0]         rd_data,
	output logic [IDX_W-1:0]   rd_idx,
	output state_t             st_nxt,
	output map_wr_t            wr,
	output result_t            res
);

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	logic [7:0] rd_ptr;
	logic [7:0] lidx8;
	logic       rd_ok;
	logic       lidx_ok;
	logic       ro;

	always_comb begin
		rd_ptr  = (item.kind == KIND_RD_ADDR_ACK) ? st.reg_ptr : st.rd_ptr;
		lidx8   = {3'b000, item.local_index};
		rd_ok   = rd_ptr < 8'(MAP_SIZE);
		lidx_ok = lidx8 < 8'(MAP_SIZE);
		ro      = (st.reg_ptr < 8'(MASK_W)) && ro_mask[st.reg_ptr[MASK_IDX_W-1:0]];
		rd_idx  = (item.kind == KIND_LOCAL_RD) ? lidx8[IDX_W-1:0] : rd_ptr[IDX_W-1:0];

		st_nxt = st;
		wr     = '0;
		res    = '0;

		unique case (item.kind)
			KIND_RD_ADDR_ACK, KIND_RD_DATA_ACK: begin
				st_nxt.rd_ptr = rd_ptr;
				if (rd_ok) begin
					res.tx_byte   = rd_data;
					st_nxt.rd_ptr = rd_ptr + 8'd1;
				end else begin
					res.tx_byte = 8'hFF;
				end
				st_nxt.busy = 1'b1;
			end
			KIND_RD_DATA_NACK, KIND_STOP: begin
				st_nxt.busy = 1'b0;
			end
			KIND_WR_ADDR_ACK: begin
				st_nxt.rx_count = '0;
				st_nxt.busy     = 1'b1;
			end
			KIND_WR_DATA_ACK: begin
				if (st.rx_count == 8'd0) begin
					st_nxt.reg_ptr  = item.data;
					st_nxt.rx_count = 8'd1;
				end else begin
					wr.en   = (st.rx_count < 8'(MAP_SIZE)) && (st.reg_ptr < 8'(MAP_SIZE))
						&& !ro;
					wr.idx  = st.reg_ptr[IDX_W-1:0];
					wr.data = item.data;
					st_nxt.rx_count = sat_inc(st.rx_count);
					st_nxt.reg_ptr  = sat_inc(st.reg_ptr);
				end
				st_nxt.busy = 1'b1;
			end
			KIND_WR_DATA_NACK: begin
				st_nxt.status   = ST_WDATA_NACK;
				res.release_bus = 1'b1;
			end
			KIND_LAST_ACK: begin
				st_nxt.status   = ST_LAST_ACK;
				res.release_bus = 1'b1;
			end
			KIND_BUS_ERR: begin
				st_nxt.status   = ST_BUS_ERR;
				res.release_bus = 1'b1;
			end
			KIND_LOCAL_WR: begin
				wr.en   = lidx_ok;
				wr.idx  = lidx8[IDX_W-1:0];
				wr.data = item.data;
			end
			KIND_LOCAL_RD: begin
				res.local_data = lidx_ok ? rd_data : 8'h00;
			end
			default: begin
				st_nxt.status = ST_UNKNOWN;
				st_nxt.busy   = 1'b0;
			end
		endcase

		res.busy_res    = st_nxt.busy;
		res.last_status = st_nxt.status;
	end

endmodule
